FILE: src/buddy_page_allocator_refcount_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the buddy page allocator
// Concurrent property wrappers for the RTL file that asserts.
// ----------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_REFCOUNT_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_REFCOUNT_MACROS_SVH

// same-cycle implication
`define BPA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BPA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Field widths, codes and helper functions of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int OP_W        = 2;
   localparam int COUNT_W     = 11;
   localparam int FRAME_W     = 10;
   localparam int STATUS_W    = 2;
   localparam int NEED_LOG_W  = 4;
   localparam int REQ_TDATA_W = 24;
   localparam int REQ_PAD_W   = REQ_TDATA_W - COUNT_W - FRAME_W;
   localparam int RSP_TDATA_W = 16;
   localparam int RSP_PAD_W   = RSP_TDATA_W - FRAME_W - STATUS_W;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC,
      OP_FREE,
      OP_REF_INC,
      OP_REF_DEC
   } bpa_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE,
      ST_NO_BLOCK,
      ST_NOT_ALLOC
   } bpa_status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_ROOT,
      S_DESC,
      S_MARK,
      S_UP_RD,
      S_UP_WR,
      S_REF_CHK,
      S_WALK,
      S_RESP
   } bpa_state_type;

   // log2 of the request rounded up to a power of two; zero counts as one
   function automatic logic [NEED_LOG_W-1:0] need_log(input logic [COUNT_W-1:0] cnt);
      logic [COUNT_W-1:0]    m;
      logic [NEED_LOG_W-1:0] r;
      m = (cnt == '0) ? '0 : cnt - COUNT_W'(1);
      r = '0;
      for (int i = 0; i < COUNT_W; i++) begin
         if (m[i]) begin
            r = NEED_LOG_W'(i + 1);
         end
      end
      return r;
   endfunction

endpackage

FILE: src/bpa_tree_ram.sv
// ----------------------------------------------------------------------------
// bpa_tree_ram
// Node store of the buddy tree: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module bpa_tree_ram #(
   parameter int DEPTH  = 2047,
   parameter int ADDR_W = 11,
   parameter int DATA_W = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [DATA_W-1:0] rd_data_a,
   output logic [DATA_W-1:0] rd_data_b
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: src/buddy_page_allocator_refcount.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator_refcount
// Buddy page-frame allocator over a binary tree of largest-free sizes, with
// a saturating reference count per frame.
// ----------------------------------------------------------------------------
// Usage:
//   req beat: tuser = operation (alloc, free, ref inc, ref dec); tdata holds
//   page_count and frame. Each request gives exactly one rsp beat carrying
//   granted_frame and status. One request is in work at a time; req_tready
//   is high only while the sequencer is idle, which does not wait for the
//   previous response to be taken (rsp has its own output register).
//   Work per request: alloc descends the tree level by level from the root,
//   marks the block and merges back up to the root with a read and a write
//   per level through the single write port of the node store; free walks up
//   from the leaf to the used node, restores it and merges back up the same
//   way. A failed alloc, a free of a frame whose count is nonzero and a ref
//   inc skip the walks; ref dec acts as ref inc, or as free when the count
//   reaches or already is zero. The next req is taken in the cycle after rsp
//   is loaded. Reset (synchronous, active high) starts a clearing pass that
//   loads every tree node and zeroes the counts; no request is accepted
//   during it. A stalled rsp holds its beat; a finished result waits until
//   the output register is free.
// ----------------------------------------------------------------------------
`include "buddy_page_allocator_refcount_macros.svh"

module buddy_page_allocator_refcount #(
   parameter int NUM_PAGES = 1024,
   parameter int REF_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [10:0] page_count, [20:11] frame, [23:21] zero
   input  logic [bpa_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [1:0] operation
   input  logic [bpa_pkg::OP_W-1:0]        req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [9:0] granted_frame, [11:10] status, [15:12] zero
   output logic [bpa_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import bpa_pkg::*;

   localparam int LEVELS     = $clog2(NUM_PAGES);
   localparam int TREE_PAGES = 1 << LEVELS;
   localparam int NODES      = 2 * TREE_PAGES - 1;
   localparam int NODE_W     = LEVELS + 1;
   localparam int LF_W       = LEVELS + 1;
   localparam int PFN_W      = LEVELS;

   bpa_state_type        state_ff, state_in;
   bpa_op_type           op_ff, op_in;
   logic [LF_W-1:0]      need_ff, need_in;
   logic                 need_big_ff, need_big_in;
   logic [FRAME_W-1:0]   frame_ff, frame_in;
   logic [NODE_W-1:0]    idx_ff, idx_in;
   logic [LF_W-1:0]      sz_ff, sz_in;
   logic [PFN_W-1:0]     pfn_ff, pfn_in;
   logic [FRAME_W-1:0]   res_granted_ff, res_granted_in;
   bpa_status_type       res_status_ff, res_status_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [FRAME_W-1:0]   rsp_granted_ff, rsp_granted_in;
   bpa_status_type       rsp_status_ff, rsp_status_in;
   logic [NODE_W-1:0]    clr_idx_ff, clr_idx_in;
   logic [LF_W-1:0]      clr_sz_ff, clr_sz_in;

   logic                 t_we;
   logic [NODE_W-1:0]    t_waddr, t_ra, t_rb;
   logic [LF_W-1:0]      t_wdata, t_qa, t_qb;

   logic                 r_we;
   logic [PFN_W-1:0]     r_waddr, r_ra;
   logic [REF_WIDTH-1:0] r_wdata;
   logic [REF_WIDTH-1:0] ref_mem [TREE_PAGES];
   logic [REF_WIDTH-1:0] ref_q_ff;

   logic [NEED_LOG_W-1:0] req_log;
   logic [NODE_W-1:0]     idx_parent, idx_left, idx_right, desc_idx, desc_left, leaf_idx;
   logic [NODE_W-1:0]     clr_next;
   logic [PFN_W-1:0]      frame_pfn;
   logic                  frame_oob;
   logic [LF_W-1:0]       pair_max;
   logic [LF_W:0]         pair_sum;
   logic [LF_W-1:0]       merge_val;

   // ---------------------------------------------------------------- datapath
   assign req_log    = need_log(req_tdata[COUNT_W-1:0]);
   assign idx_parent = (idx_ff - NODE_W'(1)) >> 1;
   assign idx_left   = NODE_W'({idx_ff, 1'b1});
   assign idx_right  = idx_left + NODE_W'(1);
   assign desc_idx   = (t_qa >= need_ff) ? idx_left : idx_right;
   assign desc_left  = NODE_W'({desc_idx, 1'b1});
   assign frame_pfn  = PFN_W'(frame_ff);
   assign frame_oob  = 32'(frame_ff) >= TREE_PAGES;
   assign leaf_idx   = NODE_W'(frame_ff) + NODE_W'(TREE_PAGES - 1);
   assign clr_next   = clr_idx_ff + NODE_W'(1);
   assign pair_max   = (t_qa > t_qb) ? t_qa : t_qb;
   assign pair_sum   = {1'b0, t_qa} + {1'b0, t_qb};
   assign merge_val  = (op_ff == OP_ALLOC)              ? pair_max :
                       (pair_sum == {1'b0, sz_ff})      ? sz_ff    : pair_max;

   bpa_tree_ram #(
      .DEPTH  (NODES),
      .ADDR_W (NODE_W),
      .DATA_W (LF_W)
   ) u_tree (
      .clock     (clock),
      .wr_en     (t_we),
      .wr_addr   (t_waddr),
      .wr_data   (t_wdata),
      .rd_addr_a (t_ra),
      .rd_addr_b (t_rb),
      .rd_data_a (t_qa),
      .rd_data_b (t_qb)
   );

   always_ff @(posedge clock) begin
      if (r_we) begin
         ref_mem[r_waddr] <= r_wdata;
      end
      ref_q_ff <= ref_mem[r_ra];
   end

   // --------------------------------------------------------------- sequencer
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      need_in        = need_ff;
      need_big_in    = need_big_ff;
      frame_in       = frame_ff;
      idx_in         = idx_ff;
      sz_in          = sz_ff;
      pfn_in         = pfn_ff;
      res_granted_in = res_granted_ff;
      res_status_in  = res_status_ff;
      rsp_tvalid_in  = rsp_tvalid_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_status_in  = rsp_status_ff;
      clr_idx_in     = clr_idx_ff;
      clr_sz_in      = clr_sz_ff;
      t_we           = 1'b0;
      t_waddr        = idx_ff;
      t_wdata        = '0;
      t_ra           = idx_ff;
      t_rb           = idx_right;
      r_we           = 1'b0;
      r_waddr        = frame_pfn;
      r_wdata        = '0;
      r_ra           = frame_pfn;
      req_tready     = 1'b0;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            t_we    = 1'b1;
            t_waddr = clr_idx_ff;
            t_wdata = clr_sz_ff;
            if (32'(clr_idx_ff) < TREE_PAGES) begin
               r_we    = 1'b1;
               r_waddr = PFN_W'(clr_idx_ff);
            end
            clr_idx_in = clr_next;
            // node count of a full level reached: next level holds half size
            if (((clr_next + NODE_W'(1)) & clr_next) == '0) begin
               clr_sz_in = clr_sz_ff >> 1;
            end
            if (clr_idx_ff == NODE_W'(NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in       = bpa_op_type'(req_tuser);
               need_in     = LF_W'(1) << req_log;
               need_big_in = 32'(req_log) > LEVELS;
               frame_in    = req_tdata[COUNT_W +: FRAME_W];
               state_in    = S_START;
            end
         end
         S_START: begin
            idx_in         = '0;
            sz_in          = LF_W'(TREE_PAGES);
            pfn_in         = '0;
            res_granted_in = '0;
            res_status_in  = ST_DONE;
            if (op_ff == OP_ALLOC) begin
               t_ra     = '0;
               state_in = S_ROOT;
            end else if (frame_oob) begin
               res_status_in = ST_NOT_ALLOC;
               state_in      = S_RESP;
            end else begin
               state_in = S_REF_CHK;
            end
         end
         S_ROOT: begin
            if (need_big_ff || t_qa < need_ff) begin
               res_status_in = ST_NO_BLOCK;
               state_in      = S_RESP;
            end else if (sz_ff == need_ff) begin
               state_in = S_MARK;
            end else begin
               t_ra     = idx_left;
               state_in = S_DESC;
            end
         end
         S_DESC: begin
            idx_in = desc_idx;
            sz_in  = sz_ff >> 1;
            t_ra   = desc_left;
            if (t_qa < need_ff) begin
               pfn_in = pfn_ff + PFN_W'(sz_ff >> 1);
            end
            if ((sz_ff >> 1) == need_ff) begin
               state_in = S_MARK;
            end
         end
         S_MARK: begin
            t_we           = 1'b1;
            t_wdata        = '0;
            r_we           = 1'b1;
            r_waddr        = pfn_ff;
            r_wdata        = REF_WIDTH'(1);
            res_granted_in = FRAME_W'(pfn_ff);
            state_in       = (idx_ff == '0) ? S_RESP : S_UP_RD;
         end
         S_UP_RD: begin
            t_ra     = NODE_W'({idx_parent, 1'b1});
            t_rb     = NODE_W'({idx_parent, 1'b1}) + NODE_W'(1);
            idx_in   = idx_parent;
            sz_in    = LF_W'({sz_ff, 1'b0});
            state_in = S_UP_WR;
         end
         S_UP_WR: begin
            t_we     = 1'b1;
            t_wdata  = merge_val;
            state_in = (idx_ff == '0) ? S_RESP : S_UP_RD;
         end
         S_REF_CHK: begin
            case (op_ff)
               OP_FREE: begin
                  if (ref_q_ff != '0) begin
                     state_in = S_RESP;
                  end else begin
                     idx_in   = leaf_idx;
                     sz_in    = LF_W'(1);
                     t_ra     = leaf_idx;
                     state_in = S_WALK;
                  end
               end
               OP_REF_INC: begin
                  if (ref_q_ff == '0) begin
                     res_status_in = ST_NOT_ALLOC;
                  end else if (ref_q_ff != '1) begin
                     r_we    = 1'b1;
                     r_wdata = ref_q_ff + REF_WIDTH'(1);
                  end
                  state_in = S_RESP;
               end
               default: begin
                  if (ref_q_ff != '0) begin
                     r_we    = 1'b1;
                     r_wdata = ref_q_ff - REF_WIDTH'(1);
                  end
                  if (ref_q_ff <= REF_WIDTH'(1)) begin
                     idx_in   = leaf_idx;
                     sz_in    = LF_W'(1);
                     t_ra     = leaf_idx;
                     state_in = S_WALK;
                  end else begin
                     state_in = S_RESP;
                  end
               end
            endcase
         end
         S_WALK: begin
            if (t_qa == '0) begin
               t_we     = 1'b1;
               t_wdata  = sz_ff;
               state_in = (idx_ff == '0) ? S_RESP : S_UP_RD;
            end else if (idx_ff == '0) begin
               res_status_in = ST_NOT_ALLOC;
               state_in      = S_RESP;
            end else begin
               idx_in = idx_parent;
               sz_in  = LF_W'({sz_ff, 1'b0});
               t_ra   = idx_parent;
            end
         end
         S_RESP: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in  = 1'b1;
               rsp_granted_in = res_granted_ff;
               rsp_status_in  = res_status_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         rsp_tvalid_ff <= 1'b0;
         clr_idx_ff    <= '0;
         clr_sz_ff     <= LF_W'(TREE_PAGES);
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         clr_idx_ff    <= clr_idx_in;
         clr_sz_ff     <= clr_sz_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      need_ff        <= need_in;
      need_big_ff    <= need_big_in;
      frame_ff       <= frame_in;
      idx_ff         <= idx_in;
      sz_ff          <= sz_in;
      pfn_ff         <= pfn_in;
      res_granted_ff <= res_granted_in;
      res_status_ff  <= res_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_status_ff, rsp_granted_ff};

   // -------------------------------------------------------------- assertions
   `BPA_ASSERT_NXT(a_accept_busy, clock, reset, req_tvalid && req_tready, state_ff == S_START, "accepted beat did not start work")
   `BPA_ASSERT_IMP(a_grant_done, clock, reset, rsp_tvalid_ff && rsp_granted_ff != '0, rsp_status_ff == ST_DONE, "granted frame on a failed response")
   `BPA_ASSERT_IMP(a_desc_size, clock, reset, state_ff == S_DESC, sz_ff > need_ff && !need_big_ff, "descent below requested block size")
   `BPA_ASSERT_IMP(a_up_nonroot, clock, reset, state_ff == S_UP_RD, idx_ff != '0, "merge step started at the root")

endmodule

FILE: tb/sv/bpa_grant_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_grant_checker
// Passive checker for the buddy page allocator. It watches both stream
// channels and keeps its own copy of the largest-free tree and the per-frame
// reference counts. Every accepted request beat is run through that copy to
// get the expected grant and status. Every accepted response beat is then
// compared against the oldest expectation still waiting.
// ----------------------------------------------------------------------------
module bpa_grant_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // [10:0] page_count, [20:11] frame, [23:21] zero
   input  logic [bpa_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [1:0] operation
   input  logic [bpa_pkg::OP_W-1:0]        req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [9:0] granted_frame, [11:10] status, [15:12] zero
   input  logic [bpa_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output int unsigned                     mismatches,
   output int unsigned                     outstanding,
   output int unsigned                     checked
);
   import bpa_pkg::*;

   localparam int          TREE_PAGES = 1024;
   localparam int          NODES      = 2 * TREE_PAGES - 1;
   localparam int unsigned REF_MAX    = 16'hFFFF;

   typedef struct {
      logic [FRAME_W-1:0] granted;
      bpa_status_type     status;
   } grant_type;

   logic [COUNT_W-1:0] node_free  [NODES];
   logic [15:0]        frame_refs [TREE_PAGES];
   grant_type          expected_grants [$];

   // walk up to the first used node, restore it, merge buddies up to the root
   function automatic bpa_status_type restore_block(input logic [FRAME_W-1:0] frame);
      int unsigned idx, span, l, r;
      if (frame_refs[frame] != 0) return ST_DONE;
      idx  = frame + TREE_PAGES - 1;
      span = 1;
      while (node_free[idx] != 0) begin
         if (idx == 0) return ST_NOT_ALLOC;
         idx  = (idx + 1) / 2 - 1;
         span = span << 1;
      end
      node_free[idx] = COUNT_W'(span);
      while (idx != 0) begin
         idx  = (idx + 1) / 2 - 1;
         span = span << 1;
         l    = node_free[2 * idx + 1];
         r    = node_free[2 * idx + 2];
         node_free[idx] = COUNT_W'((l + r == span) ? span : ((l > r) ? l : r));
      end
      return ST_DONE;
   endfunction

   function automatic grant_type predict_grant(input bpa_op_type         op,
                                               input logic [COUNT_W-1:0] cnt,
                                               input logic [FRAME_W-1:0] frame);
      grant_type   res;
      int unsigned need, idx, span, pfn, l, r;
      res.granted = '0;
      res.status  = ST_DONE;
      case (op)
         OP_ALLOC: begin
            need = 1;
            while (need < cnt) need = need << 1;
            if (node_free[0] < need) begin
               res.status = ST_NO_BLOCK;
            end else begin
               idx = 0;
               for (span = TREE_PAGES; span != need; span = span >> 1) begin
                  idx = (node_free[2 * idx + 1] >= need) ? 2 * idx + 1 : 2 * idx + 2;
               end
               node_free[idx]  = '0;
               pfn             = (idx + 1) * span - TREE_PAGES;
               frame_refs[pfn] = 16'd1;
               while (idx != 0) begin
                  idx = (idx + 1) / 2 - 1;
                  l   = node_free[2 * idx + 1];
                  r   = node_free[2 * idx + 2];
                  node_free[idx] = COUNT_W'((l > r) ? l : r);
               end
               res.granted = FRAME_W'(pfn);
            end
         end
         OP_FREE: begin
            res.status = restore_block(frame);
         end
         OP_REF_INC: begin
            if (frame_refs[frame] == 0) res.status = ST_NOT_ALLOC;
            else if (frame_refs[frame] < REF_MAX) frame_refs[frame] = frame_refs[frame] + 16'd1;
         end
         default: begin
            if (frame_refs[frame] > 0) frame_refs[frame] = frame_refs[frame] - 16'd1;
            if (frame_refs[frame] == 0) res.status = restore_block(frame);
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : watch
      grant_type   exp_beat;
      int unsigned span;
      logic [FRAME_W-1:0]  act_frame;
      logic [STATUS_W-1:0] act_status;
      if (reset) begin
         span = TREE_PAGES * 2;
         for (int i = 0; i < NODES; i++) begin
            if (((i + 1) & i) == 0) span = span >> 1;
            node_free[i] = COUNT_W'(span);
         end
         for (int i = 0; i < TREE_PAGES; i++) frame_refs[i] = '0;
         expected_grants.delete();
         mismatches = 0;
         checked    = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_grants.push_back(predict_grant(bpa_op_type'(req_tuser),
                                                    req_tdata[COUNT_W-1:0],
                                                    req_tdata[COUNT_W +: FRAME_W]));
         end
         if (rsp_tvalid && rsp_tready) begin
            act_frame  = rsp_tdata[FRAME_W-1:0];
            act_status = rsp_tdata[FRAME_W +: STATUS_W];
            checked++;
            if (expected_grants.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected rsp beat, frame %0d status %0d",
                           $realtime, act_frame, act_status);
               mismatches++;
            end else begin
               exp_beat = expected_grants.pop_front();
               if (act_frame !== exp_beat.granted || act_status !== exp_beat.status) begin
                  if (mismatches < 10)
                     $display("%0t: rsp mismatch, expected frame %0d status %s, got frame %0d status %0d",
                              $realtime, exp_beat.granted, exp_beat.status.name(),
                              act_frame, act_status);
                  mismatches++;
               end
            end
         end
      end
      outstanding = expected_grants.size();
   end

endmodule

FILE: tb/sv/tb_buddy_page_allocator_refcount.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buddy_page_allocator_refcount
// Stimulus and verdict for the buddy page allocator. The run has three parts.
// First, directed beats cover the size extremes, every operation and each
// corner of free and reference counting. Second, one frame's count is stepped
// up a few dozen times and back once. Third, random sequences allocate blocks
// and then work on the granted frames. Both channels idle at random. The
// response side also holds off once for a long stretch. The checker does the
// comparing.
// ----------------------------------------------------------------------------
module tb_buddy_page_allocator_refcount;
   import bpa_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 4_000_000;
   localparam int          N_RANDOM    = 1300;
   localparam int          N_SATURATE  = 64;
   localparam int          HOLD_CYCLES = 500;

   typedef struct {
      logic [FRAME_W-1:0] base;
      int unsigned        span;
      int unsigned        refs;
   } live_block_type;

   typedef struct {
      bpa_op_type  op;
      int unsigned span;
   } sent_req_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]        req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int unsigned mismatches, outstanding, checked;
   int unsigned sent   = 0;
   int unsigned cycles = 0;
   bit          calm      = 1'b0;
   bit          hold_req  = 1'b0;
   bit          hold_done = 1'b0;

   live_block_type live_blocks [$];
   sent_req_type   inflight [$];

   buddy_page_allocator_refcount u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   bpa_grant_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .checked     (checked)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   // response side: random idling, one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= (!calm && $urandom_range(0, 99) < 12) ? 1'b0 : 1'b1;
         end
      end
   end

   // learn granted blocks from rsp beats so later beats can target them
   always @(posedge clock) begin : track_grants
      sent_req_type   s;
      live_block_type b;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            s.op   = bpa_op_type'(req_tuser);
            s.span = (req_tdata[COUNT_W-1:0] == '0) ? 1 : req_tdata[COUNT_W-1:0];
            inflight.push_back(s);
         end
         if (rsp_tvalid && rsp_tready && inflight.size() != 0) begin
            s = inflight.pop_front();
            if (s.op == OP_ALLOC && rsp_tdata[FRAME_W +: STATUS_W] == ST_DONE) begin
               b.base = rsp_tdata[FRAME_W-1:0];
               b.span = s.span;
               b.refs = 1;
               live_blocks.push_back(b);
            end
         end
      end
   end

   task automatic send_req(input bpa_op_type         op,
                           input logic [COUNT_W-1:0] cnt,
                           input logic [FRAME_W-1:0] frame);
      if (!calm && $urandom_range(0, 99) < 12) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{REQ_PAD_W{1'b0}}, frame, cnt};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned        r, q, k, off;
      logic [COUNT_W-1:0] cnt;
      live_block_type     blk;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      send_req(OP_ALLOC,   11'd0,    10'd0);      // zero pages counts as one
      send_req(OP_ALLOC,   11'd1,    10'd1023);
      send_req(OP_ALLOC,   11'd3,    10'd0);      // rounds up to four
      send_req(OP_ALLOC,   11'd1024, 10'd0);      // no free block that large
      send_req(OP_REF_INC, 11'd0,    10'd0);
      send_req(OP_REF_INC, 11'd0,    10'd2);      // count zero
      send_req(OP_FREE,    11'd0,    10'd0);      // count nonzero, no-op
      send_req(OP_REF_DEC, 11'd0,    10'd0);      // leaves nonzero
      send_req(OP_REF_DEC, 11'd0,    10'd0);      // hits zero, frees
      send_req(OP_FREE,    11'd0,    10'd5);      // inside block, frees all four
      send_req(OP_FREE,    11'd0,    10'd5);      // no used ancestor
      send_req(OP_REF_DEC, 11'd0,    10'd7);      // zero count, nothing to free
      send_req(OP_REF_DEC, 11'd0,    10'd1);
      send_req(OP_ALLOC,   11'd1024, 10'd0);      // whole tree
      send_req(OP_REF_INC, 11'd0,    10'd1023);
      send_req(OP_REF_DEC, 11'd0,    10'd0);
      send_req(OP_ALLOC,   11'd1023, 10'd0);
      send_req(OP_ALLOC,   11'd0,    10'd0);      // nothing left
      send_req(OP_FREE,    11'd0,    10'd1023);   // last frame of whole-tree block
      send_req(OP_ALLOC,   11'd512,  10'd0);
      send_req(OP_ALLOC,   11'd512,  10'd0);
      send_req(OP_ALLOC,   11'd1,    10'd0);
      send_req(OP_REF_DEC, 11'd0,    10'd512);
      send_req(OP_REF_DEC, 11'd0,    10'd0);
      drain();

      // step one count up back to back, then step back once
      calm = 1'b1;
      send_req(OP_ALLOC, 11'd1, 10'd0);
      for (int i = 0; i < N_SATURATE; i++) send_req(OP_REF_INC, 11'd0, 10'd0);
      send_req(OP_REF_DEC, 11'd0, 10'd0);
      drain();
      calm = 1'b0;
      live_blocks.delete();

      // random sequences over granted blocks, with some noise
      for (int i = 0; i < N_RANDOM; i++) begin
         calm = (i >= 500 && i < 800);
         if (i == 300) hold_req = 1'b1;
         r = $urandom_range(0, 99);
         if (r < 6 || (live_blocks.size() == 0 && r >= 45)) begin
            send_req(bpa_op_type'($urandom_range(0, 3)), COUNT_W'($urandom_range(0, 1024)),
                     FRAME_W'($urandom_range(0, 1023)));
         end else if (r < 45) begin
            q = $urandom_range(0, 99);
            if (q < 50)      cnt = COUNT_W'($urandom_range(0, 4));
            else if (q < 80) cnt = COUNT_W'($urandom_range(5, 32));
            else if (q < 94) cnt = COUNT_W'($urandom_range(33, 256));
            else if (q < 99) cnt = COUNT_W'($urandom_range(257, 1023));
            else             cnt = 11'd1024;
            send_req(OP_ALLOC, cnt, FRAME_W'($urandom_range(0, 1023)));
         end else begin
            k   = $urandom_range(0, live_blocks.size() - 1);
            blk = live_blocks[k];
            off = (blk.span > 1) ? $urandom_range(1, blk.span - 1) : 0;
            if (r < 60 || (r >= 94 && off == 0)) begin
               blk.refs++;
               live_blocks[k] = blk;
               send_req(OP_REF_INC, COUNT_W'($urandom_range(0, 2047)), blk.base);
            end else if (r < 82) begin
               if (blk.refs <= 1) begin
                  live_blocks.delete(k);
               end else begin
                  blk.refs--;
                  live_blocks[k] = blk;
               end
               send_req(OP_REF_DEC, COUNT_W'($urandom_range(0, 2047)), blk.base);
            end else if (r < 94) begin
               if (off != 0) live_blocks.delete(k);
               send_req(OP_FREE, COUNT_W'($urandom_range(0, 2047)), FRAME_W'(blk.base + off));
            end else begin
               // decrement of a zero-count frame inside the block frees it
               live_blocks.delete(k);
               send_req(OP_REF_DEC, COUNT_W'($urandom_range(0, 2047)),
                        FRAME_W'(blk.base + off));
            end
         end
      end
      drain();

      $display("Sent %0d request beats: directed corners, a %0d-beat refcount run",
               sent, N_SATURATE);
      $display("and %0d random alloc/free/ref beats; %0d rsp beats checked, %0d mismatches",
               N_RANDOM, checked, mismatches);
      if (mismatches == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
